/* design/ffha_pkg.sv */
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and types of the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int HEAP_BYTES_DEF = 65536;

    localparam int HDR_W    = 7;
    localparam int MSP_W    = 8;
    localparam int LIM_W    = 17;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int DAT_W    = 16;
    localparam int BRK_W    = 17;
    localparam int ST_W     = 2;
    localparam int CMPW     = 21;

    localparam logic [HDR_W-1:0] HDR_RESET = 7'd24;
    localparam logic [MSP_W-1:0] MSP_RESET = 8'd8;
    localparam logic [LIM_W-1:0] LIM_RESET = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPLIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIM  = 2'd2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FND  = 2'd2;

    typedef struct packed {
        logic [DAT_W-1:0] offset;
        logic [DAT_W-1:0] size;
        logic             free;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic shift_start;
        logic coal_start;
        logic rd_run;
        logic dir_down;
        logic scan_step;
        logic coal_step;
        logic wr_split;
        logic wr_use;
        logic grow;
        logic wr_free;
        logic coal_end;
        logic set_null;
        logic set_notfound;
    } t_dp_cmd;

    typedef struct packed {
        logic op;
        logic null_rel;
        logic hit;
        logic split_now;
        logic shift_need;
        logic pipe_empty;
    } t_dp_stat;

endpackage

/* design/ffha_if.sv */
// ---------------------------------------------------------------------------
// ffha_if
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] req_size;
    logic [15:0] release_addr;
    modport source (output valid, output op, output req_size, output release_addr,
                    input ready);
    modport sink (input valid, input op, input req_size, input release_addr,
                  output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload_addr;
    logic [1:0]  status;
    modport source (output valid, output payload_addr, output status, input ready);
    modport sink (input valid, input payload_addr, input status, output ready);
endinterface

/* design/ffha_datapath.sv */
// ---------------------------------------------------------------------------
// ffha_datapath
// Block table memory, config registers, scan/shift/coalesce streams.
// ---------------------------------------------------------------------------
module ffha_datapath
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_op,
    input  logic [DAT_W-1:0]     i_req_size,
    input  logic [DAT_W-1:0]     i_release_addr,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic [DAT_W-1:0]     o_res_addr,
    output logic [ST_W-1:0]      o_res_status
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);
    localparam logic [CMPW-1:0] HEAP_LIM = CMPW'(HEAP_BYTES);

    logic [HDR_W-1:0] r_hdr;
    logic [MSP_W-1:0] r_msp;
    logic [LIM_W-1:0] r_lim;
    logic             r_op;
    logic [DAT_W-1:0] r_req, r_rel;
    logic [CW-1:0]    r_cnt, r_ra, r_ri, r_idx, r_wp;
    logic [BRK_W-1:0] r_brk;
    logic             r_rv, r_split, r_cur_v;
    t_entry           r_hit, r_cur, r_rd;
    logic [DAT_W-1:0] r_addr;
    logic [ST_W-1:0]  r_st;

    t_entry r_mem [MAX_BLOCKS];

    logic             rd_en, match, split_now, grow_ok, merge;
    logic [17:0]      need, noff, hnoff, msum, nbrk, pay;
    logic [CMPW-1:0]  lim;
    logic [CW-1:0]    idx1, ri1, wp1, cnt1;
    logic             we;
    logic [CW-1:0]    wa;
    t_entry           wd;
    logic [DAT_W-1:0] msat;

    assign idx1 = r_idx + 1'b1;
    assign ri1  = r_ri + 1'b1;
    assign wp1  = r_wp + 1'b1;
    assign cnt1 = r_cnt + 1'b1;

    assign rd_en = i_cmd.rd_run && (i_cmd.dir_down ? (r_ra > r_idx) : (r_ra < r_cnt));

    assign need  = 18'(r_req) + 18'(r_hdr) + 18'(r_msp);
    assign noff  = 18'(r_rd.offset) + 18'(r_hdr) + 18'(r_req);
    assign hnoff = 18'(r_hit.offset) + 18'(r_hdr) + 18'(r_req);
    assign match = (r_op == OP_ALLOC) ? (r_rd.free && (r_rd.size >= r_req))
                 : ((17'(r_rd.offset) + 17'(r_hdr)) == 17'(r_rel));
    assign split_now = (18'(r_rd.size) >= need) && (r_cnt < CMAX) && (noff <= 18'hFFFF);

    assign lim  = (CMPW'(r_lim) < HEAP_LIM) ? CMPW'(r_lim) : HEAP_LIM;
    assign nbrk = 18'(r_brk) + 18'(r_hdr) + 18'(r_req);
    assign pay  = 18'(r_brk) + 18'(r_hdr);
    assign grow_ok = (r_cnt < CMAX) && !r_brk[BRK_W-1] && (CMPW'(nbrk) <= lim)
                   && (pay <= 18'hFFFF);

    assign msum  = 18'(r_cur.size) + 18'(r_rd.size) + 18'(r_hdr);
    assign msat  = (msum > 18'hFFFF) ? 16'hFFFF : msum[DAT_W-1:0];
    assign merge = r_cur.free && r_rd.free;

    always_comb begin
        we = 1'b0;
        wa = r_idx;
        wd = r_hit;
        if (i_cmd.rd_run && i_cmd.dir_down && r_rv) begin
            we = 1'b1;
            wa = ri1;
            wd = r_rd;
        end else if (i_cmd.wr_split) begin
            we = 1'b1;
            wa = idx1;
            wd = '{offset: hnoff[DAT_W-1:0],
                   size: DAT_W'(18'(r_hit.size) - 18'(r_hdr) - 18'(r_req)), free: 1'b1};
        end else if (i_cmd.wr_use) begin
            we = 1'b1;
            wa = r_idx;
            wd = '{offset: r_hit.offset, size: r_split ? r_req : r_hit.size, free: 1'b0};
        end else if (i_cmd.grow && grow_ok) begin
            we = 1'b1;
            wa = r_cnt;
            wd = '{offset: r_brk[DAT_W-1:0], size: r_req, free: 1'b0};
        end else if (i_cmd.wr_free) begin
            we = 1'b1;
            wa = r_idx;
            wd = '{offset: r_hit.offset, size: r_hit.size, free: 1'b1};
        end else if (i_cmd.coal_step && r_rv && r_cur_v && !merge) begin
            we = 1'b1;
            wa = r_wp;
            wd = r_cur;
        end else if (i_cmd.coal_end) begin
            we = 1'b1;
            wa = r_wp;
            wd = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa[AW-1:0]] <= wd;
        end
        if (rd_en) begin
            r_rd <= r_mem[r_ra[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= HDR_RESET;
            r_msp <= MSP_RESET;
            r_lim <= LIM_RESET;
            r_cnt <= '0;
            r_brk <= '0;
            r_rv  <= 1'b0;
            r_ra  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HEADER:    r_hdr <= i_cfg_data[HDR_W-1:0];
                    CFG_MIN_SPLIT: r_msp <= i_cfg_data[MSP_W-1:0];
                    CFG_HEAP_LIM:  r_lim <= i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.scan_start || i_cmd.coal_start) begin
                r_ra <= '0;
                r_rv <= 1'b0;
            end else if (i_cmd.shift_start) begin
                r_ra <= r_cnt - 1'b1;
                r_rv <= 1'b0;
            end else begin
                r_rv <= rd_en;
                if (rd_en) begin
                    r_ra <= i_cmd.dir_down ? r_ra - 1'b1 : r_ra + 1'b1;
                end
            end
            if (i_cmd.wr_split || (i_cmd.grow && grow_ok)) begin
                r_cnt <= cnt1;
            end else if (i_cmd.coal_end) begin
                r_cnt <= wp1;
            end
            if (i_cmd.grow && grow_ok) begin
                r_brk <= nbrk[BRK_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_ri <= r_ra;
        end
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_req <= i_req_size;
            r_rel <= i_release_addr;
        end
        if (i_cmd.scan_step && r_rv && match) begin
            r_idx   <= r_ri;
            r_hit   <= r_rd;
            r_split <= split_now;
        end
        if (i_cmd.coal_start) begin
            r_wp    <= '0;
            r_cur_v <= 1'b0;
        end else if (i_cmd.coal_step && r_rv) begin
            r_cur_v <= 1'b1;
            if (!r_cur_v) begin
                r_cur <= r_rd;
            end else if (merge) begin
                r_cur.size <= msat;
            end else begin
                r_wp  <= wp1;
                r_cur <= r_rd;
            end
        end
        if (i_cmd.set_null || i_cmd.wr_free) begin
            r_addr <= '0;
            r_st   <= ST_OK;
        end else if (i_cmd.set_notfound) begin
            r_addr <= '0;
            r_st   <= ST_NOT_FND;
        end else if (i_cmd.wr_use) begin
            r_addr <= DAT_W'(17'(r_hit.offset) + 17'(r_hdr));
            r_st   <= ST_OK;
        end else if (i_cmd.grow) begin
            r_addr <= grow_ok ? pay[DAT_W-1:0] : '0;
            r_st   <= grow_ok ? ST_OK : ST_NO_SPACE;
        end
    end

    assign o_stat = '{op: r_op,
                      null_rel: (i_op == OP_RELEASE) && (i_release_addr == '0),
                      hit: r_rv && match,
                      split_now: split_now,
                      shift_need: ri1 < r_cnt,
                      pipe_empty: !rd_en && !r_rv};
    assign o_res_addr   = r_addr;
    assign o_res_status = r_st;

endmodule

/* design/ffha_ctrl.sv */
// ---------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for scan, split, grow, release and coalesce phases.
// ---------------------------------------------------------------------------
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_load_out,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SCAN   = 10'b0000000010,
        S_SHIFT  = 10'b0000000100,
        S_WSPLIT = 10'b0000001000,
        S_WUSE   = 10'b0000010000,
        S_GROW   = 10'b0000100000,
        S_WFREE  = 10'b0001000000,
        S_COAL   = 10'b0010000000,
        S_CEND   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.null_rel) begin
                        o_cmd.set_null = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_run    = 1'b1;
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit) begin
                    if (i_stat.op == OP_RELEASE) begin
                        n_state = S_WFREE;
                    end else if (i_stat.split_now) begin
                        if (i_stat.shift_need) begin
                            o_cmd.shift_start = 1'b1;
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_WSPLIT;
                        end
                    end else begin
                        n_state = S_WUSE;
                    end
                end else if (i_stat.pipe_empty) begin
                    if (i_stat.op == OP_RELEASE) begin
                        o_cmd.set_notfound = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_GROW;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.rd_run   = 1'b1;
                o_cmd.dir_down = 1'b1;
                if (i_stat.pipe_empty) begin
                    n_state = S_WSPLIT;
                end
            end
            S_WSPLIT: begin
                o_cmd.wr_split = 1'b1;
                n_state = S_WUSE;
            end
            S_WUSE: begin
                o_cmd.wr_use = 1'b1;
                n_state = S_DONE;
            end
            S_GROW: begin
                o_cmd.grow = 1'b1;
                n_state = S_DONE;
            end
            S_WFREE: begin
                o_cmd.wr_free    = 1'b1;
                o_cmd.coal_start = 1'b1;
                n_state = S_COAL;
            end
            S_COAL: begin
                o_cmd.rd_run    = 1'b1;
                o_cmd.coal_step = 1'b1;
                if (i_stat.pipe_empty) begin
                    n_state = S_CEND;
                end
            end
            S_CEND: begin
                o_cmd.coal_end = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/first_fit_heap_allocator.sv */
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// Allocate: first-fit scan, then a shift and split write, a use write or growth;
// release: scan, free and a coalesce pass; a null release skips the scan.
// Throughput: one item at a time, set by the single-port walks over the table.
// Reset: synchronous active low; empty table, break 0, config to defaults.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ffha_req_if.sink             i_req,
    ffha_rsp_if.source           o_rsp
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic             load_out, out_free;
    logic [DAT_W-1:0] res_addr;
    logic [ST_W-1:0]  res_st;
    logic             r_ov;
    logic [DAT_W-1:0] r_oaddr;
    logic [ST_W-1:0]  r_ost;

    assign out_free = !r_ov || o_rsp.ready;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (i_req.ready),
        .o_load_out (load_out),
        .o_cmd      (cmd)
    );

    ffha_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_req.op),
        .i_req_size     (i_req.req_size),
        .i_release_addr (i_req.release_addr),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_res_addr     (res_addr),
        .o_res_status   (res_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_oaddr <= res_addr;
            r_ost   <= res_st;
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.payload_addr = r_oaddr;
    assign o_rsp.status       = r_ost;

endmodule

/* test/first_fit_heap_allocator_test.sv */
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_test
// Self-checking testbench: allocate/release items go through the request
// channel, an internal block-table predictor computes each expected response,
// and the monitor compares address and status. Several register settings.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator_test;
    import ffha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             op;
        logic [DAT_W-1:0] req_size;
        logic [DAT_W-1:0] release_addr;
    } t_req;

    typedef struct packed {
        logic [DAT_W-1:0] payload_addr;
        logic [ST_W-1:0]  status;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();

    first_fit_heap_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    // predictor state
    int unsigned hdr_bytes, split_min, lim_bytes;
    logic [DAT_W-1:0] tbl_off [MAX_BLOCKS_DEF];
    logic [DAT_W-1:0] tbl_size [MAX_BLOCKS_DEF];
    logic tbl_free [MAX_BLOCKS_DEF];
    int unsigned tbl_count, brk;

    t_req pending_items[$];
    t_rsp expected_rsps[$];
    int errors = 0;
    int n_alloc = 0, n_release = 0, n_rsp = 0, n_fail = 0, n_notfound = 0;
    bit idle_en = 1;
    bit in_taken = 0;
    int src_gap = 0, snk_gap = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void table_insert(int unsigned pos);
        for (int unsigned k = tbl_count; k > pos; k--) begin
            tbl_off[k] = tbl_off[k-1];
            tbl_size[k] = tbl_size[k-1];
            tbl_free[k] = tbl_free[k-1];
        end
        tbl_count++;
    endfunction

    function automatic void table_remove(int unsigned pos);
        for (int unsigned k = pos; k + 1 < tbl_count; k++) begin
            tbl_off[k] = tbl_off[k+1];
            tbl_size[k] = tbl_size[k+1];
            tbl_free[k] = tbl_free[k+1];
        end
        tbl_count--;
    endfunction

    function automatic t_rsp heap_predict(t_req it);
        t_rsp r;
        int unsigned sz, noff, nbrk, pay, lim;
        int unsigned j;
        bit done;
        r = '0;
        done = 0;
        if (it.op == OP_ALLOC) begin
            for (int unsigned i = 0; i < tbl_count && !done; i++) begin
                if (tbl_free[i] && tbl_size[i] >= it.req_size) begin
                    sz = tbl_size[i];
                    noff = tbl_off[i] + hdr_bytes + it.req_size;
                    tbl_free[i] = 0;
                    if (sz >= it.req_size + hdr_bytes + split_min &&
                        tbl_count < MAX_BLOCKS_DEF && noff <= 16'hFFFF) begin
                        table_insert(i + 1);
                        tbl_off[i+1] = noff[15:0];
                        tbl_size[i+1] = 16'(sz - hdr_bytes - it.req_size);
                        tbl_free[i+1] = 1;
                        tbl_size[i] = it.req_size;
                    end
                    r.payload_addr = 16'(tbl_off[i] + hdr_bytes);
                    done = 1;
                end
            end
            if (!done) begin
                lim = lim_bytes < HEAP_BYTES_DEF ? lim_bytes : HEAP_BYTES_DEF;
                nbrk = brk + hdr_bytes + it.req_size;
                pay = brk + hdr_bytes;
                if (tbl_count >= MAX_BLOCKS_DEF || brk > 16'hFFFF || nbrk > lim ||
                    pay > 16'hFFFF) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    tbl_off[tbl_count] = brk[15:0];
                    tbl_size[tbl_count] = it.req_size;
                    tbl_free[tbl_count] = 0;
                    tbl_count++;
                    brk = nbrk;
                    r.payload_addr = pay[15:0];
                end
            end
        end else if (it.release_addr != 0) begin
            r.status = ST_NOT_FND;
            for (int unsigned i = 0; i < tbl_count && !done; i++) begin
                if (tbl_off[i] + hdr_bytes == it.release_addr) begin
                    tbl_free[i] = 1;
                    done = 1;
                    r.status = ST_OK;
                end
            end
            if (done) begin
                j = 0;
                while (j + 1 < tbl_count) begin
                    if (tbl_free[j] && tbl_free[j+1]) begin
                        sz = tbl_size[j] + tbl_size[j+1] + hdr_bytes;
                        tbl_size[j] = sz > 16'hFFFF ? 16'hFFFF : 16'(sz);
                        table_remove(j + 1);
                    end else begin
                        j++;
                    end
                end
            end
        end
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 0;
        end else if (!req_ch.valid || in_taken) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                req_ch.valid <= 0;
            end else if (idle_en && $urandom_range(7) == 0) begin
                src_gap <= $urandom_range(5, 1) - 1;
                req_ch.valid <= 0;
            end else if (pending_items.size() > 0) begin
                req_ch.valid <= 1;
                {req_ch.op, req_ch.req_size, req_ch.release_addr} <= pending_items[0];
            end else begin
                req_ch.valid <= 0;
            end
        end
        if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            rsp_ch.ready <= 0;
        end else if (idle_en && $urandom_range(7) == 0) begin
            snk_gap <= $urandom_range(5, 1) - 1;
            rsp_ch.ready <= 0;
        end else begin
            rsp_ch.ready <= 1;
        end
    end

    // acceptance and monitor
    always @(posedge i_clk) begin
        t_rsp got, exp_r;
        t_req it;
        in_taken <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            it = {req_ch.op, req_ch.req_size, req_ch.release_addr};
            void'(pending_items.pop_front());
            if (it.op == OP_ALLOC) n_alloc++; else n_release++;
            expected_rsps.push_back(heap_predict(it));
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.payload_addr, rsp_ch.status};
            n_rsp++;
            if (expected_rsps.size() == 0) begin
                errors++;
                $display("%t unexpected response addr=%0d status=%0d", $realtime,
                         got.payload_addr, got.status);
            end else begin
                exp_r = expected_rsps.pop_front();
                if (got.status == ST_NO_SPACE) n_fail++;
                if (got.status == ST_NOT_FND) n_notfound++;
                if (got.payload_addr != exp_r.payload_addr) begin
                    errors++;
                    $display("%t payload_addr expected %0d actual %0d", $realtime,
                             exp_r.payload_addr, got.payload_addr);
                end
                if (got.status != exp_r.status) begin
                    errors++;
                    $display("%t status expected %0d actual %0d", $realtime,
                             exp_r.status, got.status);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_HEADER:    hdr_bytes = val & 7'h7F;
            CFG_MIN_SPLIT: split_min = val & 8'hFF;
            CFG_HEAP_LIM:  lim_bytes = val & 17'h1FFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_rsps.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // picks a table entry's payload address when one exists, else or sometimes a random one
    function automatic logic [DAT_W-1:0] pick_release();
        int unsigned k;
        if (tbl_count == 0 || $urandom_range(9) == 0) return 16'($urandom);
        k = $urandom_range(tbl_count - 1);
        return 16'(tbl_off[k] + hdr_bytes);
    endfunction

    task automatic push_alloc(int unsigned sz);
        pending_items.push_back({OP_ALLOC, 16'(sz), 16'($urandom)});
    endtask

    task automatic push_release(int unsigned a);
        pending_items.push_back({OP_RELEASE, 16'($urandom), 16'(a)});
    endtask

    // releases are chosen against the predictor, so each release waits until all
    // earlier items are answered and its address is picked once the table is settled
    task automatic random_phase(int n, int unsigned max_sz);
        repeat (n) begin
            if ($urandom_range(1)) begin
                push_alloc($urandom_range(4) == 0 ? $urandom : $urandom_range(max_sz));
            end else begin
                while (pending_items.size() > 0 || expected_rsps.size() > 0)
                    @(posedge i_clk);
                push_release(pick_release());
            end
        end
        drain();
    endtask

    initial begin
        hdr_bytes = HDR_RESET;
        split_min = MSP_RESET;
        lim_bytes = LIM_RESET;
        tbl_count = 0;
        brk = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_HEADER;
        i_cfg_data = '0;
        req_ch.valid = 0;
        req_ch.op = OP_ALLOC;
        req_ch.req_size = '0;
        req_ch.release_addr = '0;
        rsp_ch.ready = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: growth, null/unknown release, split, coalesce, double release
        push_alloc(0);
        push_alloc(100);
        push_alloc(40);
        push_alloc(65535);
        push_release(0);
        push_release(16'hFFFF);
        push_release(24 + 24);
        push_release(24 + 24);
        push_release(24);
        push_alloc(10);
        push_alloc(200);
        push_release(24 + 24 + 100 + 24);
        push_alloc(65000);
        drain();
        // header 0 lets a block sit at payload 0, small limit forces failures
        write_reg(CFG_HEADER, 0);
        write_reg(CFG_MIN_SPLIT, 0);
        write_reg(CFG_HEAP_LIM, 0);
        push_alloc(0);
        push_alloc(1);
        push_release(0);
        drain();
        write_reg(CFG_HEAP_LIM, 512);
        push_alloc(0);
        push_alloc(600);
        push_alloc(512);
        push_release(24);
        drain();

        write_reg(CFG_HEADER, 64);
        write_reg(CFG_MIN_SPLIT, 255);
        write_reg(CFG_HEAP_LIM, 17'h1FFFF);
        random_phase(300, 600);
        write_reg(CFG_HEADER, 8);
        write_reg(CFG_MIN_SPLIT, 0);
        random_phase(300, 300);
        write_reg(CFG_HEADER, $urandom_range(64));
        write_reg(CFG_MIN_SPLIT, $urandom_range(255));
        write_reg(CFG_HEAP_LIM, $urandom_range(65536, 1000));
        random_phase(300, 2000);
        idle_en = 0;
        write_reg(CFG_HEADER, 127);
        write_reg(CFG_MIN_SPLIT, 16);
        write_reg(CFG_HEAP_LIM, 65536);
        random_phase(300, 100);

        $display("covered %0d allocates, %0d releases, %0d responses", n_alloc, n_release,
                 n_rsp);
        $display("no-space responses %0d, not-found responses %0d", n_fail, n_notfound);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
